// ===== rtl/core/biq_pkg.sv =====
package biq_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 32;
	localparam int COEF_FRAC = COEF_W - 4;
	localparam int DELAY_W   = 48;
	localparam int DFRAC     = 16;
	localparam int GAIN_W    = 17;
	localparam int GAIN_FRAC = GAIN_W - 1;
	localparam int TIME_W    = 63;
	localparam int CFG_IDX_W = 3;
	localparam int QDEPTH    = 2;

	localparam int MUL_A_W = COEF_W + 1;
	localparam int MUL_B_W = SAMPLE_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int YSPLIT  = DELAY_W - SAMPLE_W;
	localparam int FULL_W  = PROD_W + YSPLIT;
	localparam int DSUM_W  = FULL_W - COEF_FRAC;
	localparam int GP_W    = FULL_W - 2 * DFRAC;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << GAIN_FRAC);
	localparam logic signed [COEF_W-1:0] COEF_UNITY = COEF_W'(1 << COEF_FRAC);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FF0 = 3'd0,
		CFG_FF1 = 3'd1,
		CFG_FF2 = 3'd2,
		CFG_FB1 = 3'd3,
		CFG_FB2 = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] ff0;
		logic signed [COEF_W-1:0] ff1;
		logic signed [COEF_W-1:0] ff2;
		logic signed [COEF_W-1:0] fb1;
		logic signed [COEF_W-1:0] fb2;
	} coef_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [GAIN_W-1:0]          gain;
		logic                       enabled;
		logic                       fading;
	} q_entry_t;

	typedef struct packed {
		logic     push;
		q_entry_t data;
	} q_wr_t;

	typedef struct packed {
		logic     avail;
		q_entry_t data;
	} q_rd_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_RAMP,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_FF,
		B_Y,
		B_HI,
		B_LO,
		B_SUM,
		B_UPD
	} back_state_t;

endpackage

// ===== rtl/core/biq_if.sv =====
interface biq_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic signed [biq_pkg::SAMPLE_W-1:0]  sample_in;
	logic [biq_pkg::TIME_W-1:0]           time_ns;
	logic                                 enable_value;
	logic                                 loop_running;

	modport source (
		output valid, req_type, sample_in, time_ns, enable_value, loop_running,
		input  ready
	);
	modport sink (
		input  valid, req_type, sample_in, time_ns, enable_value, loop_running,
		output ready
	);
endinterface

interface biq_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [biq_pkg::SAMPLE_W-1:0]  sample_out;
	logic                                 filter_enabled;
	logic                                 fading;

	modport source (
		output valid, sample_out, filter_enabled, fading,
		input  ready
	);
	modport sink (
		input  valid, sample_out, filter_enabled, fading,
		output ready
	);
endinterface

// ===== rtl/core/biquad_filter_with_enable_ramp.sv =====
// Biquad section, transposed direct form II, Q4.28 coefficients, with a linear
// gain fade of RAMP_NS ns timed by the sample timestamps. Enable requests give
// no result. A sample gives one result; the filter datapath runs each sample
// through states FF, Y, HI, LO, SUM and UPD on three shared multipliers
// (forward products, then the feedback and gain products in two halves of the
// 48-bit output), and takes no new sample until it is done with the last. While
// a fade is mid-way, the gain is found by a reciprocal multiply and one
// correction step in the control front, which takes no new sample until the
// last is queued. A two-entry queue sits between control and datapath, and
// results leave through a registered output that holds under backpressure.
// Coefficients must be written only while idle; the block does not enforce this.
module biquad_filter_with_enable_ramp #(
	parameter int RAMP_NS = 20000000
) (
	input  logic                              clk,
	input  logic                              arst_n,
	biq_in_if.sink                            din,
	biq_out_if.source                         dout,
	input  logic                              cfg_we,
	input  logic [biq_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [biq_pkg::COEF_W-1:0]        cfg_wdata
);
	import biq_pkg::*;

	coef_t coef_q;
	q_wr_t qwr;
	q_rd_t qrd;
	logic  qfull, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '{ff0: COEF_UNITY, ff1: '0, ff2: '0, fb1: '0, fb2: '0};
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_FF0: coef_q.ff0 <= cfg_wdata;
				CFG_FF1: coef_q.ff1 <= cfg_wdata;
				CFG_FF2: coef_q.ff2 <= cfg_wdata;
				CFG_FB1: coef_q.fb1 <= cfg_wdata;
				CFG_FB2: coef_q.fb2 <= cfg_wdata;
				default: ;
			endcase
		end
	end

	biq_front #(
		.RAMP_NS (RAMP_NS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.qwr    (qwr),
		.qfull  (qfull)
	);

	biq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qwr    (qwr),
		.qfull  (qfull),
		.pop    (pop),
		.qrd    (qrd)
	);

	biq_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef_q),
		.qrd    (qrd),
		.pop    (pop),
		.dout   (dout)
	);

endmodule

// ===== rtl/core/biq_front.sv =====
module biq_front #(
	parameter int RAMP_NS = 20000000
) (
	input  logic            clk,
	input  logic            arst_n,
	biq_in_if.sink          din,
	output biq_pkg::q_wr_t  qwr,
	input  logic            qfull
);
	import biq_pkg::*;

	localparam int     RAMP_W = $clog2(RAMP_NS + 1);
	localparam int     NUM_W  = RAMP_W + GAIN_FRAC;
	localparam int     RCP_W  = GAIN_FRAC + 2;
	localparam longint RCP_V  = (longint'(1) << NUM_W) / longint'(RAMP_NS);
	localparam logic [TIME_W-1:0] RAMP_T = TIME_W'(RAMP_NS);
	localparam logic [NUM_W-1:0]  RAMP_N = NUM_W'(RAMP_NS);
	localparam logic [RCP_W-1:0]  RCP    = RCP_W'(RCP_V);

	front_state_t state_q, state_d;

	logic                       enabled_q, disabling_q, active_q, started_q;
	logic [TIME_W-1:0]          start_q;
	logic [GAIN_W-1:0]          gain_q;
	logic [TIME_W-1:0]          time_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [RAMP_W-1:0]          rem_q;
	logic [GAIN_FRAC-1:0]       quo_q;
	logic                       cnt_q;

	logic                  acc;
	logic [TIME_W-1:0]     delta;
	logic                  over, at_end, last;
	logic [NUM_W+1:0]      rprod;
	logic [NUM_W-1:0]      qprod, resid;
	logic                  ge;
	logic [GAIN_FRAC-1:0]  quo_d;

	assign acc = din.valid && din.ready;

	// fade position
	assign delta  = (time_q >= start_q) ? time_q - start_q : '0;
	assign over   = delta > RAMP_T;
	assign at_end = delta == RAMP_T;

	// reciprocal estimate, low by at most one, then one correction step
	assign rprod = (NUM_W + 2)'(rem_q) * (NUM_W + 2)'(RCP);
	assign qprod = NUM_W'(quo_q) * RAMP_N;
	assign resid = {rem_q, {GAIN_FRAC{1'b0}}} - qprod;
	assign ge    = resid >= RAMP_N;
	assign quo_d = quo_q + GAIN_FRAC'(ge);
	assign last  = cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (acc && !din.req_type && active_q) state_d = F_RAMP;
			end
			F_RAMP: begin
				if (over || at_end) state_d = F_PUSH;
				else state_d = F_DIV;
			end
			F_DIV: begin
				if (last) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!qfull) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		din.ready = 1'b0;
		qwr.push  = 1'b0;
		qwr.data  = '{sample: sample_q, gain: gain_q, enabled: enabled_q, fading: active_q};
		unique case (state_q)
			F_IDLE: begin
				din.ready = !qfull;
				qwr.push  = acc && !din.req_type && !active_q;
				qwr.data.sample = din.sample_in;
			end
			F_PUSH: begin
				qwr.push = !qfull;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			enabled_q   <= 1'b0;
			disabling_q <= 1'b0;
			active_q    <= 1'b0;
			started_q   <= 1'b0;
			start_q     <= '0;
			gain_q      <= UNITY_GAIN;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				F_IDLE: begin
					if (acc) begin
						if (din.req_type) begin
							if (!din.loop_running) begin
								enabled_q <= din.enable_value;
							end else if (!(enabled_q == din.enable_value ||
									(!enabled_q && disabling_q))) begin
								if (!enabled_q) enabled_q <= 1'b1;
								else disabling_q <= 1'b1;
								active_q  <= 1'b1;
								started_q <= 1'b0;
								start_q   <= '0;
							end
						end else if (active_q && !started_q) begin
							start_q   <= din.time_ns;
							started_q <= 1'b1;
						end
					end
				end
				F_RAMP: begin
					if (over) begin
						active_q  <= 1'b0;
						started_q <= 1'b0;
						start_q   <= '0;
						if (disabling_q) begin
							disabling_q <= 1'b0;
							enabled_q   <= 1'b0;
							gain_q      <= '0;
						end else begin
							gain_q <= UNITY_GAIN;
						end
					end else if (at_end) begin
						gain_q <= disabling_q ? '0 : UNITY_GAIN;
					end
				end
				F_DIV: begin
					if (last) begin
						gain_q <= disabling_q ? UNITY_GAIN - {1'b0, quo_d} : {1'b0, quo_d};
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && acc) begin
			time_q   <= din.time_ns;
			sample_q <= din.sample_in;
		end
		if (state_q == F_RAMP) begin
			rem_q <= delta[RAMP_W-1:0];
			cnt_q <= 1'b0;
		end else if (state_q == F_DIV && !cnt_q) begin
			quo_q <= rprod[RAMP_W +: GAIN_FRAC];
			cnt_q <= 1'b1;
		end
	end

endmodule

// ===== rtl/core/biq_queue.sv =====
module biq_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  biq_pkg::q_wr_t  qwr,
	output logic            qfull,
	input  logic            pop,
	output biq_pkg::q_rd_t  qrd
);
	import biq_pkg::*;

	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	q_entry_t        mem_q [QDEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign qfull     = cnt_q == CNT_W'(QDEPTH);
	assign qrd.avail = cnt_q != '0;
	assign qrd.data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (qwr.push) wp_q <= (wp_q == PTR_W'(QDEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			if (pop) rp_q <= (rp_q == PTR_W'(QDEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			unique case ({qwr.push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (qwr.push) mem_q[wp_q] <= qwr.data;
	end

endmodule

// ===== rtl/core/biq_back.sv =====
module biq_back (
	input  logic            clk,
	input  logic            arst_n,
	input  biq_pkg::coef_t  coef,
	input  biq_pkg::q_rd_t  qrd,
	output logic            pop,
	biq_out_if.source       dout
);
	import biq_pkg::*;

	localparam int NMUL     = 3;
	localparam int FF_SHIFT = COEF_FRAC - DFRAC;

	function automatic logic signed [DELAY_W-1:0] sat_delay(
		input logic signed [DSUM_W-1:0] v);
		if (&v[DSUM_W-1:DELAY_W-1] || ~|v[DSUM_W-1:DELAY_W-1])
			return v[DELAY_W-1:0];
		else if (v[DSUM_W-1])
			return {1'b1, {(DELAY_W-1){1'b0}}};
		else
			return {1'b0, {(DELAY_W-1){1'b1}}};
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [GP_W-1:0] v);
		if (&v[GP_W-1:SAMPLE_W-1] || ~|v[GP_W-1:SAMPLE_W-1])
			return v[SAMPLE_W-1:0];
		else if (v[GP_W-1])
			return {1'b1, {(SAMPLE_W-1){1'b0}}};
		else
			return {1'b0, {(SAMPLE_W-1){1'b1}}};
	endfunction

	back_state_t state_q, state_d;

	logic signed [SAMPLE_W-1:0] sample_q;
	logic [GAIN_W-1:0]          gain_q;
	logic                       en_q, fad_q;
	logic signed [PROD_W-1:0]   prod_ff_q [NMUL];
	logic signed [PROD_W-1:0]   prod_hi_q [NMUL];
	logic signed [PROD_W-1:0]   prod_lo_q [NMUL];
	logic signed [DELAY_W-1:0]  y_q, d1_q, d2_q;
	logic signed [DSUM_W-1:0]   fb1p_q, fb2p_q;
	logic signed [GP_W-1:0]     gp_q;

	logic                       ovalid_q;
	logic signed [SAMPLE_W-1:0] osample_q;
	logic                       oen_q, ofad_q;

	logic                       slot_free, load;
	logic signed [MUL_A_W-1:0]  mul_a [NMUL];
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   prod [NMUL];
	logic signed [DSUM_W-1:0]   pf0, pf1, pf2;
	logic signed [FULL_W-1:0]   full1, full2, fullg;
	logic [SAMPLE_W-1:0]        yhi;
	logic [YSPLIT-1:0]          ylo;

	assign slot_free = !ovalid_q || dout.ready;
	assign yhi = y_q[DELAY_W-1:YSPLIT];
	assign ylo = y_q[YSPLIT-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (qrd.avail) state_d = B_FF;
			B_FF:    state_d = B_Y;
			B_Y:     state_d = B_HI;
			B_HI:    state_d = B_LO;
			B_LO:    state_d = B_SUM;
			B_SUM:   state_d = B_UPD;
			B_UPD:   if (slot_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		load = 1'b0;
		mul_b = '0;
		for (int i = 0; i < NMUL; i++) mul_a[i] = '0;
		unique case (state_q)
			B_IDLE: pop = qrd.avail;
			B_FF: begin
				mul_a[0] = {coef.ff0[COEF_W-1], coef.ff0};
				mul_a[1] = {coef.ff1[COEF_W-1], coef.ff1};
				mul_a[2] = {coef.ff2[COEF_W-1], coef.ff2};
				mul_b    = {sample_q[SAMPLE_W-1], sample_q};
			end
			B_HI, B_LO: begin
				mul_a[0] = {coef.fb1[COEF_W-1], coef.fb1};
				mul_a[1] = {coef.fb2[COEF_W-1], coef.fb2};
				mul_a[2] = {{(MUL_A_W-GAIN_W){1'b0}}, gain_q};
				mul_b    = (state_q == B_HI) ? {yhi[SAMPLE_W-1], yhi} : {1'b0, ylo};
			end
			B_UPD: load = slot_free;
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < NMUL; i++) prod[i] = mul_a[i] * mul_b;
		pf0 = DSUM_W'(prod_ff_q[0] >>> FF_SHIFT);
		pf1 = DSUM_W'(prod_ff_q[1] >>> FF_SHIFT);
		pf2 = DSUM_W'(prod_ff_q[2] >>> FF_SHIFT);
		full1 = (FULL_W'(prod_hi_q[0]) <<< YSPLIT) + FULL_W'(prod_lo_q[0]);
		full2 = (FULL_W'(prod_hi_q[1]) <<< YSPLIT) + FULL_W'(prod_lo_q[1]);
		fullg = (FULL_W'(prod_hi_q[2]) <<< YSPLIT) + FULL_W'(prod_lo_q[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			ovalid_q <= 1'b0;
			d1_q     <= '0;
			d2_q     <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				ovalid_q <= 1'b1;
				d1_q     <= sat_delay(pf1 + DSUM_W'(d2_q) - fb1p_q);
				d2_q     <= sat_delay(pf2 - fb2p_q);
			end else if (dout.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sample_q <= qrd.data.sample;
			gain_q   <= qrd.data.gain;
			en_q     <= qrd.data.enabled;
			fad_q    <= qrd.data.fading;
		end
		if (state_q == B_FF) prod_ff_q <= prod;
		if (state_q == B_Y) y_q <= sat_delay(pf0 + DSUM_W'(d1_q));
		if (state_q == B_HI) prod_hi_q <= prod;
		if (state_q == B_LO) prod_lo_q <= prod;
		if (state_q == B_SUM) begin
			fb1p_q <= DSUM_W'(full1 >>> COEF_FRAC);
			fb2p_q <= DSUM_W'(full2 >>> COEF_FRAC);
			gp_q   <= GP_W'(fullg >>> (2 * DFRAC));
		end
		if (load) begin
			osample_q <= sat_sample(gp_q);
			oen_q     <= en_q;
			ofad_q    <= fad_q;
		end
	end

	assign dout.valid          = ovalid_q;
	assign dout.sample_out     = osample_q;
	assign dout.filter_enabled = oen_q;
	assign dout.fading         = ofad_q;

endmodule

// ===== rtl/core/biq_checker.sv =====
module biq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [biq_pkg::SAMPLE_W-1:0]      out_sample,
	input logic                              out_en,
	input logic                              out_fad
);
	logic out_hs;
	assign out_hs = out_valid && out_ready;

	a_rst_no_valid: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	a_valid_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_payload_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample) && $stable(out_en) && $stable(out_fad))
		else $error("result changed while stalled");

	// datapath finishes each sample before taking the next: at most two back-to-back transactions
	a_no_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs ##1 out_hs |=> !out_hs)
		else $error("three results in consecutive cycles");

endmodule

bind biquad_filter_with_enable_ramp biq_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.out_sample (dout.sample_out),
	.out_en     (dout.filter_enabled),
	.out_fad    (dout.fading)
);
